// ----- design/ipc_pkg.sv -----
// ----------------------------------------------------------------------------
// ipc_pkg
// Types, constants and selection functions shared by the interrupt
// priority controller front end, back end and top level.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int NUM_SOURCES = 8;
    localparam int QUEUE_DEPTH = 2;

    // Commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_LINE  = 2'd2;

    // Register indexes
    localparam logic [3:0] REG_MASK    = 4'd8;
    localparam logic [3:0] REG_PRIMASK = 4'd9;
    localparam logic [3:0] REG_ISR     = 4'd10;
    localparam logic [3:0] REG_IRR     = 4'd11;
    localparam logic [3:0] REG_EOI     = 4'd12;
    localparam logic [3:0] REG_STATUS  = 4'd13;
    localparam logic [3:0] REG_POLLST  = 4'd14;
    localparam logic [3:0] REG_POLL    = 4'd15;

    // Line identifiers
    localparam logic [2:0] LINE_TMR2   = 3'd2;
    localparam logic [2:0] LINE_INT1   = 3'd6;

    // Sources
    localparam logic [2:0] SRC_TIMER   = 3'd0;
    localparam logic [2:0] SRC_NONE    = 3'd1;
    localparam logic [2:0] SRC_INT0    = 3'd4;
    localparam logic [2:0] SRC_INT1    = 3'd5;

    localparam logic [7:0]  VALID_SOURCES = 8'hfd;
    localparam logic [15:0] EOI_FLAG      = 16'h8000;
    localparam logic [15:0] POLL_FLAG     = 16'h8000;
    localparam logic [15:0] TMR_KEEP      = 16'hfff8;

    // Control word bits
    localparam int CON_MSK  = 3;
    localparam int CON_LVL  = 4;
    localparam int CON_CAS  = 5;
    localparam int CON_SFNM = 6;

    localparam logic [4:0] VTYPE_BASE = 5'd8;
    localparam logic [4:0] VTYPE_TMR1 = 5'd18;
    localparam logic [4:0] VTYPE_TMR2 = 5'd19;

    localparam logic [1:0] CAS_NONE = 2'd0;
    localparam logic [1:0] CAS_INT0 = 2'd1;
    localparam logic [1:0] CAS_INT1 = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WR_CON,
        OP_WR_MASK,
        OP_WR_PRI,
        OP_WR_ISR,
        OP_WR_IRR,
        OP_EOI,
        OP_WR_TMR,
        OP_RD_REG,
        OP_POLL_STATUS,
        OP_POLL,
        OP_LINE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  idx;
        logic [15:0] data;
        logic [2:0]  src;
        logic [2:0]  tmr;
        logic        level;
    } item_t;

    typedef logic [6:0] con_word_t;
    typedef con_word_t [NUM_SOURCES-1:0] con_array_t;

    typedef struct packed {
        logic       found;
        logic [2:0] src;
        logic [4:0] vtype;
    } pick_t;

    typedef struct packed {
        logic       found;
        logic [2:0] src;
    } eoi_t;

    function automatic con_word_t con_wmask(input logic [2:0] src);
        con_word_t m;
        unique case (src)
            3'd0, 3'd2, 3'd3: m = 7'h0f;
            3'd4, 3'd5:       m = 7'h7f;
            3'd6, 3'd7:       m = 7'h1f;
            default:          m = 7'h00;
        endcase
        return m;
    endfunction

    // Highest eligible request, scanned from source 7 down to source 0
    function automatic pick_t pick_request(
        input con_array_t  con,
        input logic [7:0]  mask,
        input logic [7:0]  isr,
        input logic [7:0]  req,
        input logic [2:0]  pmask,
        input logic [2:0]  tstat
    );
        pick_t      p;
        logic [2:0] best_pri;
        logic [2:0] pri;
        p.found  = 1'b0;
        p.src    = 3'd0;
        p.vtype  = VTYPE_BASE;
        best_pri = 3'd7;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            pri = con[i][2:0];
            if (VALID_SOURCES[i] && !mask[i] && pri <= best_pri && pri <= pmask) begin
                if (isr[i] && !con[i][CON_SFNM]) begin
                    p.found  = 1'b0;
                    best_pri = 3'd7;
                end else if (req[i]) begin
                    p.found  = 1'b1;
                    p.src    = 3'(i);
                    best_pri = pri;
                end
            end
        end
        p.vtype = VTYPE_BASE + {2'b00, p.src};
        if (p.src == SRC_TIMER) begin
            if (tstat[0])
                p.vtype = VTYPE_BASE;
            else if (tstat[1])
                p.vtype = VTYPE_TMR1;
            else if (tstat[2])
                p.vtype = VTYPE_TMR2;
        end
        return p;
    endfunction

    // In-service source of highest priority
    function automatic eoi_t eoi_pick(input con_array_t con, input logic [7:0] isr);
        eoi_t       e;
        logic [2:0] best_pri;
        e.found  = 1'b0;
        e.src    = 3'd0;
        best_pri = 3'd7;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (VALID_SOURCES[i] && isr[i] && con[i][2:0] <= best_pri) begin
                e.found  = 1'b1;
                e.src    = 3'(i);
                best_pri = con[i][2:0];
            end
        end
        return e;
    endfunction

endpackage

// ----- design/ipc_front.sv -----
// ----------------------------------------------------------------------------
// ipc_front
// Accepts commands, decodes them into operations and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module ipc_front
    import ipc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [3:0]  reg_index,
    input  logic [15:0] write_data,
    input  logic [2:0]  line_id,
    input  logic        line_level,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      dec;
    logic       push;

    always_comb
    begin
        dec.op    = OP_NOP;
        dec.idx   = reg_index;
        dec.data  = write_data;
        dec.src   = reg_index[2:0];
        dec.tmr   = 3'b000;
        dec.level = line_level;
        unique case (command)
            CMD_WRITE:
            begin
                if (!reg_index[3]) begin
                    dec.op = VALID_SOURCES[reg_index[2:0]] ? OP_WR_CON : OP_NOP;
                end else begin
                    unique case (reg_index)
                        REG_MASK:    dec.op = OP_WR_MASK;
                        REG_PRIMASK: dec.op = OP_WR_PRI;
                        REG_ISR:     dec.op = OP_WR_ISR;
                        REG_IRR:     dec.op = OP_WR_IRR;
                        REG_EOI:     dec.op = (write_data & EOI_FLAG) != 16'h0 ? OP_EOI : OP_NOP;
                        REG_STATUS:  dec.op = OP_WR_TMR;
                        default:     dec.op = OP_NOP;
                    endcase
                end
            end
            CMD_READ:
            begin
                unique case (reg_index)
                    REG_POLLST: dec.op = OP_POLL_STATUS;
                    REG_POLL:   dec.op = OP_POLL;
                    default:    dec.op = OP_RD_REG;
                endcase
            end
            CMD_LINE:
            begin
                if (line_id <= LINE_TMR2) begin
                    dec.op  = OP_LINE;
                    dec.src = SRC_TIMER;
                    dec.tmr = 3'b001 << line_id;
                end else if (line_id <= LINE_INT1) begin
                    dec.op  = OP_LINE;
                    dec.src = line_id - 3'd1;
                end
            end
            default: dec.op = OP_NOP;
        endcase
    end

    assign busy    = (count_reg == 2'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 2'd1;
        else if (!push && q_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= dec;
    end

endmodule

// ----- design/ipc_core.sv -----
// ----------------------------------------------------------------------------
// ipc_core
// Back end: holds the controller state, carries out one queued operation
// and then reports read data, cascade status and the INTR level.
// ----------------------------------------------------------------------------
module ipc_core
    import ipc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        done,
    output logic [15:0] read_data,
    output logic        intr_level,
    output logic [1:0]  cascade_ack
);

    typedef enum logic [1:0] {
        ST_WAIT   = 2'b01,
        ST_FINISH = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] req_reg, req_next;
    logic [15:0] mask_reg, mask_next;
    logic [15:0] isr_reg, isr_next;
    logic [15:0] pmask_reg, pmask_next;
    logic [15:0] tstat_reg, tstat_next;
    con_array_t  con_reg, con_next;
    logic [7:0]  lvl_reg, lvl_next;
    logic [15:0] rd_reg, rd_next;
    logic [1:0]  cas_reg, cas_next;
    logic        done_reg, done_next;
    logic        intr_reg, intr_next;
    logic [15:0] out_rd_reg, out_rd_next;
    logic [1:0]  out_cas_reg, out_cas_next;
    pick_t       pk;
    eoi_t        eo;
    logic [15:0] sbit;
    logic [15:0] rd_val;

    assign pk = pick_request(con_reg, mask_reg[7:0], isr_reg[7:0], req_reg[7:0],
                             pmask_reg[2:0], tstat_reg[2:0]);
    assign eo = eoi_pick(con_reg, isr_reg[7:0]);
    assign q_pop = (state_reg == ST_WAIT) && q_valid;
    assign sbit  = 16'h0001 << q_item.src;

    always_comb
    begin
        rd_val = 16'h0000;
        if (!q_item.idx[3]) begin
            if (q_item.idx[2:0] != SRC_NONE)
                rd_val = {9'h000, con_reg[q_item.idx[2:0]]};
        end else begin
            case (q_item.idx)
                REG_MASK:    rd_val = mask_reg;
                REG_PRIMASK: rd_val = pmask_reg;
                REG_ISR:     rd_val = isr_reg;
                REG_IRR:     rd_val = req_reg;
                REG_STATUS:  rd_val = tstat_reg;
                default:     rd_val = 16'h0000;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        mask_next    = mask_reg;
        isr_next     = isr_reg;
        pmask_next   = pmask_reg;
        tstat_next   = tstat_reg;
        con_next     = con_reg;
        lvl_next     = lvl_reg;
        rd_next      = rd_reg;
        cas_next     = cas_reg;
        done_next    = 1'b0;
        intr_next    = intr_reg;
        out_rd_next  = out_rd_reg;
        out_cas_next = out_cas_reg;
        unique case (state_reg)
            ST_WAIT:
            begin
                if (q_valid) begin
                    rd_next    = 16'h0000;
                    cas_next   = CAS_NONE;
                    state_next = ST_FINISH;
                    case (q_item.op)
                        OP_WR_CON:
                        begin
                            con_next[q_item.src] = q_item.data[6:0] & con_wmask(q_item.src);
                            mask_next = q_item.data[CON_MSK] ? (mask_reg | sbit)
                                                             : (mask_reg & ~sbit);
                        end
                        OP_WR_MASK:
                        begin
                            mask_next = q_item.data;
                            for (int i = 0; i < NUM_SOURCES; i++)
                                con_next[i][CON_MSK] = q_item.data[i];
                        end
                        OP_WR_PRI: pmask_next = q_item.data;
                        OP_WR_ISR: isr_next   = q_item.data;
                        OP_WR_IRR: req_next   = q_item.data;
                        OP_WR_TMR: tstat_next = q_item.data;
                        OP_EOI:
                        begin
                            if (eo.found)
                                isr_next = isr_reg & ~(16'h0001 << eo.src);
                        end
                        OP_RD_REG: rd_next = rd_val;
                        OP_POLL_STATUS:
                        begin
                            if (pk.found)
                                rd_next = POLL_FLAG | {11'h000, pk.vtype};
                        end
                        OP_POLL:
                        begin
                            if (pk.found) begin
                                if (!con_reg[pk.src][CON_LVL])
                                    req_next = req_reg & ~(16'h0001 << pk.src);
                                isr_next = isr_reg | (16'h0001 << pk.src);
                                if (pk.src == SRC_TIMER)
                                    tstat_next = tstat_reg & ((tstat_reg - 16'd1) | TMR_KEEP);
                                if (con_reg[pk.src][CON_CAS] && pk.src == SRC_INT0)
                                    cas_next = CAS_INT0;
                                else if (con_reg[pk.src][CON_CAS] && pk.src == SRC_INT1)
                                    cas_next = CAS_INT1;
                                else
                                    rd_next = POLL_FLAG | {11'h000, pk.vtype};
                            end
                        end
                        OP_LINE:
                        begin
                            if (q_item.level)
                                tstat_next = tstat_reg | {13'h0000, q_item.tmr};
                            else
                                tstat_next = tstat_reg & ~{13'h0000, q_item.tmr};
                            // act only on a real change of level
                            if (q_item.level && !lvl_reg[q_item.src]) begin
                                lvl_next[q_item.src] = 1'b1;
                                req_next = req_reg | sbit;
                            end else if (!q_item.level && lvl_reg[q_item.src]) begin
                                lvl_next[q_item.src] = 1'b0;
                                req_next = req_reg & ~sbit;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FINISH:
            begin
                // state now reflects the operation: sample INTR and report
                done_next    = 1'b1;
                intr_next    = pk.found;
                out_rd_next  = rd_reg;
                out_cas_next = cas_reg;
                state_next   = ST_WAIT;
            end
            default: state_next = ST_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_WAIT;
            req_reg     <= 16'h0000;
            mask_reg    <= 16'h0000;
            isr_reg     <= 16'h0000;
            pmask_reg   <= 16'h0007;
            tstat_reg   <= 16'h0000;
            con_reg     <= '0;
            lvl_reg     <= 8'h00;
            done_reg    <= 1'b0;
            intr_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            req_reg     <= req_next;
            mask_reg    <= mask_next;
            isr_reg     <= isr_next;
            pmask_reg   <= pmask_next;
            tstat_reg   <= tstat_next;
            con_reg     <= con_next;
            lvl_reg     <= lvl_next;
            done_reg    <= done_next;
            intr_reg    <= intr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg      <= rd_next;
        cas_reg     <= cas_next;
        out_rd_reg  <= out_rd_next;
        out_cas_reg <= out_cas_next;
    end

    assign done        = done_reg;
    assign read_data   = out_rd_reg;
    assign intr_level  = intr_reg;
    assign cascade_ack = out_cas_reg;

`ifndef ASSERT_OFF
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("results reported in consecutive cycles");

    a_cas_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && out_cas_reg != CAS_NONE |-> out_rd_reg == 16'h0000)
        else $error("cascade acknowledge carries read data");

    a_cas_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |->
            (out_cas_reg == CAS_NONE || out_cas_reg == CAS_INT0 || out_cas_reg == CAS_INT1))
        else $error("illegal cascade code");

    a_pop_then_report: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop ##1 done_reg)
        else $error("operation not reported two cycles after pop");

    a_unused_lines: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg[7:6] == 2'b00)
        else $error("level kept for a line that does not exist");
`endif

endmodule

// ----- design/interrupt_priority_controller_unit.sv -----
// ----------------------------------------------------------------------------
// interrupt_priority_controller_unit
// Seven-source prioritised interrupt controller with register access,
// polling, nonspecific EOI and source line events.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge with start high and busy low. The back
// end sequencer takes each command through an execute state and then an
// INTR sampling state, and pops the next command only after both; a two-entry
// queue between decode and execution lets start be taken while earlier
// commands are pending, and busy rises only when both entries are held.
// The result appears with done high for one cycle, registered at the end of
// the sampling state. The receiver cannot stall: read_data, intr_level and
// cascade_ack must be captured while done is high.
module interrupt_priority_controller_unit
    import ipc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [3:0]  reg_index,
    input  logic [15:0] write_data,
    input  logic [2:0]  line_id,
    input  logic        line_level,
    output logic        done,
    output logic [15:0] read_data,
    output logic        intr_level,
    output logic [1:0]  cascade_ack
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    ipc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .reg_index  (reg_index),
        .write_data (write_data),
        .line_id    (line_id),
        .line_level (line_level),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    ipc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .done        (done),
        .read_data   (read_data),
        .intr_level  (intr_level),
        .cascade_ack (cascade_ack)
    );

endmodule

// ----- sim/tb_interrupt_priority_controller_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interrupt_priority_controller_unit
// Runs directed and random register, poll, EOI and line traffic through the
// interrupt controller. Results are compared field by field with a local
// model of the request, mask, in-service and priority logic.
// ----------------------------------------------------------------------------
module tb_interrupt_priority_controller_unit;

    import ipc_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_CMDS  = 1500;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [2:0] LINE_TMR0   = 3'd0;
    localparam logic [2:0] LINE_TMR1   = 3'd1;
    localparam logic [2:0] LINE_UNUSED = 3'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  reg_index;
        logic [15:0] write_data;
        logic [2:0]  line_id;
        logic        line_level;
    } irq_cmd_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        intr_level;
        logic [1:0]  cascade_ack;
    } irq_result_t;

    typedef struct packed {
        logic       found;
        logic [2:0] src;
        logic [4:0] vtype;
    } grant_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [1:0]  command    = CMD_WRITE;
    logic [3:0]  reg_index  = 4'd0;
    logic [15:0] write_data = 16'd0;
    logic [2:0]  line_id    = 3'd0;
    logic        line_level = 1'b0;
    logic        busy;
    logic        done;
    logic [15:0] read_data;
    logic        intr_level;
    logic [1:0]  cascade_ack;

    // Controller state as the testbench sees it
    logic [15:0] req_bits;
    logic [15:0] msk_bits;
    logic [15:0] isr_bits;
    logic [15:0] pri_mask;
    logic [15:0] tmr_status;
    logic [6:0]  ctl_word [NUM_SOURCES];
    logic [7:0]  line_hi;

    irq_cmd_t    pending_cmds [$];
    irq_result_t expected_results [$];
    irq_cmd_t    taken_cmd;
    irq_result_t seen;
    irq_result_t wanted;
    int          idle_left;
    int          burst_left;
    int          error_count;
    int          cycle_count;

    interrupt_priority_controller_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .line_id     (line_id),
        .line_level  (line_level),
        .done        (done),
        .read_data   (read_data),
        .intr_level  (intr_level),
        .cascade_ack (cascade_ack)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_state();
        req_bits   = 16'd0;
        msk_bits   = 16'd0;
        isr_bits   = 16'd0;
        pri_mask   = 16'd7;
        tmr_status = 16'd0;
        line_hi    = 8'd0;
        for (int i = 0; i < NUM_SOURCES; i++)
            ctl_word[i] = 7'd0;
    endfunction

    function automatic logic [6:0] ctl_width(input logic [2:0] src);
        case (src)
            3'd0, 3'd2, 3'd3: return 7'h0f;
            3'd4, 3'd5:       return 7'h7f;
            3'd6, 3'd7:       return 7'h1f;
            default:          return 7'h00;
        endcase
    endfunction

    // Walk from source 7 down; an in-service source without SFNM blocks
    // everything found so far at its level or below
    function automatic grant_t find_grant();
        grant_t     g;
        logic [2:0] best_pri;
        logic [2:0] pri;
        g.found  = 1'b0;
        g.src    = 3'd0;
        best_pri = 3'd7;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            pri = ctl_word[i][2:0];
            if (VALID_SOURCES[i] && !msk_bits[i] && pri <= best_pri && pri <= pri_mask[2:0])
            begin
                if (isr_bits[i] && !ctl_word[i][CON_SFNM])
                begin
                    g.found  = 1'b0;
                    best_pri = 3'd7;
                end
                else if (req_bits[i])
                begin
                    g.found  = 1'b1;
                    g.src    = 3'(i);
                    best_pri = pri;
                end
            end
        end
        g.vtype = VTYPE_BASE + {2'b00, g.src};
        if (g.src == SRC_TIMER)
        begin
            if (tmr_status[0])
                g.vtype = VTYPE_BASE;
            else if (tmr_status[1])
                g.vtype = VTYPE_TMR1;
            else if (tmr_status[2])
                g.vtype = VTYPE_TMR2;
        end
        return g;
    endfunction

    function automatic void end_of_interrupt();
        int         top;
        logic [2:0] best_pri;
        top      = -1;
        best_pri = 3'd7;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (VALID_SOURCES[i] && isr_bits[i] && ctl_word[i][2:0] <= best_pri)
            begin
                top      = i;
                best_pri = ctl_word[i][2:0];
            end
        end
        if (top >= 0)
            isr_bits[top] = 1'b0;
    endfunction

    // Only a real level change touches the request bit
    function automatic void drive_line(input logic [2:0] src, input logic level);
        if (level != line_hi[src])
        begin
            line_hi[src]  = level;
            req_bits[src] = level;
        end
    endfunction

    function automatic irq_result_t apply_command(input irq_cmd_t c);
        irq_result_t r;
        grant_t      g;
        logic [2:0]  s;
        r.read_data   = 16'd0;
        r.cascade_ack = CAS_NONE;
        s = c.reg_index[2:0];
        case (c.command)
            CMD_WRITE:
            begin
                if (!c.reg_index[3])
                begin
                    if (VALID_SOURCES[s])
                    begin
                        ctl_word[s] = c.write_data[6:0] & ctl_width(s);
                        msk_bits[s] = c.write_data[CON_MSK];
                    end
                end
                else
                begin
                    case (c.reg_index)
                        REG_MASK:
                        begin
                            msk_bits = c.write_data;
                            for (int i = 0; i < NUM_SOURCES; i++)
                                ctl_word[i][CON_MSK] = c.write_data[i];
                        end
                        REG_PRIMASK: pri_mask   = c.write_data;
                        REG_ISR:     isr_bits   = c.write_data;
                        REG_IRR:     req_bits   = c.write_data;
                        REG_EOI:     if ((c.write_data & EOI_FLAG) != 16'd0) end_of_interrupt();
                        REG_STATUS:  tmr_status = c.write_data;
                        default:     ;
                    endcase
                end
            end
            CMD_READ:
            begin
                if (!c.reg_index[3])
                    r.read_data = VALID_SOURCES[s] ? {9'd0, ctl_word[s]} : 16'd0;
                else
                begin
                    case (c.reg_index)
                        REG_MASK:    r.read_data = msk_bits;
                        REG_PRIMASK: r.read_data = pri_mask;
                        REG_ISR:     r.read_data = isr_bits;
                        REG_IRR:     r.read_data = req_bits;
                        REG_STATUS:  r.read_data = tmr_status;
                        REG_POLLST:
                        begin
                            g = find_grant();
                            if (g.found)
                                r.read_data = {11'd0, g.vtype} | POLL_FLAG;
                        end
                        REG_POLL:
                        begin
                            g = find_grant();
                            if (g.found)
                            begin
                                // acknowledge: edge requests drop, in-service bit set
                                if (!ctl_word[g.src][CON_LVL])
                                    req_bits[g.src] = 1'b0;
                                isr_bits[g.src] = 1'b1;
                                if (g.src == SRC_TIMER)
                                    tmr_status = tmr_status & ((tmr_status - 16'd1) | TMR_KEEP);
                                r.read_data = {11'd0, g.vtype} | POLL_FLAG;
                                if (ctl_word[g.src][CON_CAS] && g.src == SRC_INT0)
                                begin
                                    r.cascade_ack = CAS_INT0;
                                    r.read_data   = 16'd0;
                                end
                                else if (ctl_word[g.src][CON_CAS] && g.src == SRC_INT1)
                                begin
                                    r.cascade_ack = CAS_INT1;
                                    r.read_data   = 16'd0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_LINE:
            begin
                // all three timers share source 0
                if (c.line_id <= LINE_TMR2)
                begin
                    tmr_status[c.line_id] = c.line_level;
                    drive_line(SRC_TIMER, c.line_level);
                end
                else if (c.line_id <= LINE_INT1)
                    drive_line(c.line_id - 3'd1, c.line_level);
            end
            default: ;
        endcase
        g = find_grant();
        r.intr_level = g.found;
        return r;
    endfunction

    function automatic void queue_cmd(input logic [1:0] cmd, input logic [3:0] idx,
                                      input logic [15:0] data, input logic [2:0] line,
                                      input logic level);
        irq_cmd_t c;
        c.command    = cmd;
        c.reg_index  = idx;
        c.write_data = data;
        c.line_id    = line;
        c.line_level = level;
        pending_cmds.push_back(c);
    endfunction

    // Mostly short gaps, a few long ones, and bursts with none at all
    function automatic int next_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Driver: hold the transfer while busy, then idle or present the next command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                taken_cmd = {command, reg_index, write_data, line_id, line_level};
                expected_results.push_back(apply_command(taken_cmd));
            end
            if (!(start && busy))
            begin
                if (idle_left > 0)
                begin
                    start     <= 1'b0;
                    idle_left <= idle_left - 1;
                end
                else if (pending_cmds.size() != 0)
                begin
                    taken_cmd   = pending_cmds.pop_front();
                    command    <= taken_cmd.command;
                    reg_index  <= taken_cmd.reg_index;
                    write_data <= taken_cmd.write_data;
                    line_id    <= taken_cmd.line_id;
                    line_level <= taken_cmd.line_level;
                    start      <= 1'b1;
                    idle_left  <= next_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: results are valid for the single cycle that done is high
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen = {read_data, intr_level, cascade_ack};
            if (expected_results.size() == 0)
            begin
                if (error_count < 10)
                    $display("Unexpected result: read_data %h intr %b cascade %0d",
                             seen.read_data, seen.intr_level, seen.cascade_ack);
                error_count++;
            end
            else
            begin
                wanted = expected_results.pop_front();
                if (seen.read_data !== wanted.read_data || seen.intr_level !== wanted.intr_level
                    || seen.cascade_ack !== wanted.cascade_ack)
                begin
                    if (error_count < 10)
                        $display("Mismatch: read_data %h/%h intr %b/%b cascade %0d/%0d (exp/act)",
                                 wanted.read_data, seen.read_data, wanted.intr_level,
                                 seen.intr_level, wanted.cascade_ack, seen.cascade_ack);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int         roll;
        int         added;
        logic [2:0] ln;
        logic [3:0] ridx;
        error_count = 0;
        burst_left  = 0;
        clear_state();

        // Missing source one, cascade on both external inputs, SFNM with level trigger
        queue_cmd(CMD_READ,  {1'b0, SRC_NONE}, 16'h0000, LINE_TMR0, 1'b0);
        queue_cmd(CMD_WRITE, {1'b0, SRC_NONE}, 16'hffff, LINE_TMR0, 1'b0);
        queue_cmd(CMD_READ,  {1'b0, SRC_NONE}, 16'h0000, LINE_TMR0, 1'b0);
        queue_cmd(CMD_WRITE, {1'b0, SRC_INT0}, 16'h0021, LINE_TMR0, 1'b0);
        queue_cmd(CMD_LINE,  REG_MASK, 16'h0000, LINE_INT1 - 3'd1, 1'b1);
        queue_cmd(CMD_READ,  REG_POLLST, 16'h0000, LINE_TMR0, 1'b0);
        queue_cmd(CMD_READ,  REG_POLL, 16'h0000, LINE_TMR0, 1'b0);
        queue_cmd(CMD_WRITE, REG_EOI, EOI_FLAG, LINE_TMR0, 1'b0);
        queue_cmd(CMD_WRITE, {1'b0, SRC_INT1}, 16'h0070, LINE_TMR0, 1'b0);
        queue_cmd(CMD_LINE,  REG_MASK, 16'h0000, LINE_INT1, 1'b1);
        queue_cmd(CMD_READ,  REG_POLL, 16'h0000, LINE_TMR0, 1'b0);
        queue_cmd(CMD_READ,  REG_POLL, 16'h0000, LINE_TMR0, 1'b0);
        // EOI without the flag, with it, and as a read
        queue_cmd(CMD_WRITE, REG_EOI, 16'h7fff, LINE_TMR0, 1'b0);
        queue_cmd(CMD_WRITE, REG_EOI, 16'hffff, LINE_TMR0, 1'b0);
        queue_cmd(CMD_READ,  REG_EOI, 16'h0000, LINE_TMR0, 1'b0);
        queue_cmd(CMD_LINE,  REG_MASK, 16'h0000, LINE_INT1, 1'b0);
        // Timer vector selection
        queue_cmd(CMD_LINE,  REG_MASK, 16'h0000, LINE_TMR1, 1'b1);
        queue_cmd(CMD_LINE,  REG_MASK, 16'h0000, LINE_TMR2, 1'b1);
        queue_cmd(CMD_READ,  REG_POLL, 16'h0000, LINE_TMR0, 1'b0);
        // Ignored writes, unused line and unused command
        queue_cmd(CMD_WRITE, REG_POLLST, 16'hffff, LINE_TMR0, 1'b0);
        queue_cmd(CMD_WRITE, REG_POLL, 16'hffff, LINE_TMR0, 1'b0);
        queue_cmd(CMD_LINE,  REG_MASK, 16'hffff, LINE_UNUSED, 1'b1);
        queue_cmd(CMD_UNUSED, REG_POLL, 16'hffff, LINE_UNUSED, 1'b1);
        // Poll with everything masked, then the priority mask extremes
        queue_cmd(CMD_WRITE, REG_MASK, 16'hffff, LINE_TMR0, 1'b0);
        queue_cmd(CMD_READ,  REG_POLL, 16'h0000, LINE_TMR0, 1'b0);
        queue_cmd(CMD_WRITE, REG_MASK, 16'h0000, LINE_TMR0, 1'b0);
        queue_cmd(CMD_WRITE, REG_PRIMASK, 16'h0000, LINE_TMR0, 1'b0);
        queue_cmd(CMD_WRITE, REG_PRIMASK, 16'hffff, LINE_TMR0, 1'b0);

        added = 0;
        while (added < RANDOM_CMDS)
        begin
            roll = $urandom_range(0, 99);
            ln   = 3'($urandom_range(0, 6));
            if (roll < 25)
            begin
                // raise, acknowledge, end of interrupt, release
                queue_cmd(CMD_LINE, 4'($urandom), 16'($urandom), ln, 1'b1);
                added++;
                if ($urandom_range(0, 1))
                begin
                    queue_cmd(CMD_READ, REG_POLLST, 16'($urandom), 3'($urandom), 1'($urandom));
                    added++;
                end
                queue_cmd(CMD_READ, REG_POLL, 16'($urandom), 3'($urandom), 1'($urandom));
                added++;
                if ($urandom_range(0, 9) < 7)
                begin
                    queue_cmd(CMD_WRITE, REG_EOI, 16'($urandom) | EOI_FLAG,
                              3'($urandom), 1'($urandom));
                    added++;
                end
                if ($urandom_range(0, 9) < 6)
                begin
                    queue_cmd(CMD_LINE, 4'($urandom), 16'($urandom), ln, 1'b0);
                    added++;
                end
            end
            else
            begin
                if (roll < 45)
                    queue_cmd(CMD_LINE, 4'($urandom), 16'($urandom),
                              ($urandom_range(0, 19) == 0) ? LINE_UNUSED : ln, 1'($urandom));
                else if (roll < 55)
                    queue_cmd(CMD_READ, ($urandom_range(0, 2) == 0) ? REG_POLLST : REG_POLL,
                              16'($urandom), 3'($urandom), 1'($urandom));
                else if (roll < 62)
                    queue_cmd(CMD_WRITE, REG_EOI,
                              ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                                          : (16'($urandom) | EOI_FLAG),
                              3'($urandom), 1'($urandom));
                else if (roll < 72)
                    // keep most sources unmasked
                    queue_cmd(CMD_WRITE, 4'($urandom_range(0, 7)),
                              ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : (16'($urandom) & 16'hfff7),
                              3'($urandom), 1'($urandom));
                else if (roll < 77)
                    queue_cmd(CMD_WRITE, REG_MASK,
                              ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                          : (16'($urandom) & 16'($urandom) &
                                                             16'($urandom) & 16'h00ff),
                              3'($urandom), 1'($urandom));
                else if (roll < 80)
                    queue_cmd(CMD_WRITE, REG_PRIMASK,
                              ($urandom_range(0, 1) == 0) ? 16'd7 : 16'($urandom),
                              3'($urandom), 1'($urandom));
                else if (roll < 84)
                begin
                    case ($urandom_range(0, 2))
                        0:       ridx = REG_ISR;
                        1:       ridx = REG_IRR;
                        default: ridx = REG_STATUS;
                    endcase
                    queue_cmd(CMD_WRITE, ridx,
                              (ridx == REG_ISR && $urandom_range(0, 3) != 0)
                                  ? (16'($urandom) & 16'($urandom) & 16'h00ff)
                                  : 16'($urandom),
                              3'($urandom), 1'($urandom));
                end
                else if (roll < 97)
                    queue_cmd(CMD_READ, 4'($urandom), 16'($urandom), 3'($urandom),
                              1'($urandom));
                else if (roll < 99)
                    queue_cmd(CMD_WRITE, ($urandom_range(0, 1) == 0) ? REG_POLL : REG_POLLST,
                              16'($urandom), 3'($urandom), 1'($urandom));
                else
                    queue_cmd(CMD_UNUSED, 4'($urandom), 16'($urandom), 3'($urandom),
                              1'($urandom));
                added++;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ipc_pkg.sv
design/ipc_front.sv
design/ipc_core.sv
design/interrupt_priority_controller_unit.sv
sim/tb_interrupt_priority_controller_unit.sv
